/* src/krwm_pkg.sv */
// Shared types and constants for the keystroke rate window meter.
package krwm_pkg;

   localparam int DATA_W = 16;
   localparam int CMD_W  = 2;
   localparam int LAG_W  = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_KEY   = 2'd0,
      CMD_SLICE = 2'd1,
      CMD_HIST  = 2'd2,
      CMD_QUERY = 2'd3
   } krwm_cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_HIST,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } krwm_state_type;

   typedef struct packed {
      logic start;
      logic valid;
      logic slice_ok;
      logic hist_ok;
      logic lag_hit;
   } krwm_scan_ctl_type;

endpackage

/* src/krwm_if.sv */
// Request and response channel interfaces of the keystroke rate window meter.
interface krwm_req_if
   import krwm_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [LAG_W-1:0] lag;

   modport source (output valid, output cmd, output lag, input ready);
   modport sink (input valid, input cmd, input lag, output ready);
endinterface

interface krwm_rsp_if
   import krwm_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] rate_sum;
   logic [DATA_W-1:0] history_peak;
   logic [DATA_W-1:0] history_at_lag;

   modport source (output valid, output rate_sum, output history_peak,
                   output history_at_lag, input ready);
   modport sink (input valid, input rate_sum, input history_peak,
                 input history_at_lag, output ready);
endinterface

/* src/krwm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module krwm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/krwm_scan.sv */
// Accumulator for window sum, history peak and lagged history entry.
module krwm_scan
   import krwm_pkg::*;
(
   input  logic              clock,
   input  krwm_scan_ctl_type ctl,
   input  logic [DATA_W-1:0] slice_data,
   input  logic [DATA_W-1:0] hist_data,
   output logic [DATA_W-1:0] rate_sum,
   output logic [DATA_W-1:0] history_peak,
   output logic [DATA_W-1:0] history_at_lag
);

   logic [DATA_W-1:0] sum_ff, sum_in;
   logic [DATA_W-1:0] peak_ff, peak_in;
   logic [DATA_W-1:0] lag_val_ff, lag_val_in;

   always_comb begin
      sum_in     = sum_ff;
      peak_in    = peak_ff;
      lag_val_in = lag_val_ff;
      if (ctl.start) begin
         sum_in     = '0;
         peak_in    = '0;
         lag_val_in = '0;
      end else if (ctl.valid) begin
         if (ctl.slice_ok) begin
            sum_in = sum_ff + slice_data;
         end
         if (ctl.hist_ok && (hist_data > peak_ff)) begin
            peak_in = hist_data;
         end
         if (ctl.lag_hit) begin
            lag_val_in = hist_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff     <= sum_in;
      peak_ff    <= peak_in;
      lag_val_ff <= lag_val_in;
   end

   assign rate_sum       = sum_ff;
   assign history_peak   = peak_ff;
   assign history_at_lag = lag_val_ff;

endmodule

/* src/keystroke_rate_window_meter_top.sv */
// Keystroke rate window meter: slice and history rings in RAM, scanned per request.
// A request runs ST_SCAN, one read per entry, over N = max(SLICES_PER_WINDOW,
// HISTORY_DEPTH) entries, then ST_DRAIN and ST_DONE (ST_WR_HIST first for a
// history timer); no new request is taken until ST_DONE loads the response.
// Reset: synchronous; a clearing pass over N entries zeroes both rings, requests wait.
module keystroke_rate_window_meter_top
   import krwm_pkg::*;
#(
   parameter int SLICES_PER_WINDOW = 8,
   parameter int HISTORY_DEPTH     = 64
) (
   input  logic        clock,
   input  logic        reset,
   krwm_req_if.sink    req_bus,
   krwm_rsp_if.source  rsp_bus
);

   localparam int SW = (SLICES_PER_WINDOW > 1) ? $clog2(SLICES_PER_WINDOW) : 1;
   localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SCAN_N = (SLICES_PER_WINDOW > HISTORY_DEPTH) ?
                           SLICES_PER_WINDOW : HISTORY_DEPTH;
   localparam int CW = $clog2(SCAN_N + 1);

   krwm_state_type    state_ff, state_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              rd_valid_ff;
   logic [CW-1:0]     rd_idx_ff;
   logic [LAG_W-1:0]  lag_ff, lag_in;
   logic [DATA_W-1:0] slice_count_ff, slice_count_in;
   logic [SW-1:0]     sptr_ff, sptr_in, sptr_adv;
   logic [HW-1:0]     hptr_ff, hptr_in, hptr_adv;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_sum_ff, rsp_peak_ff, rsp_lag_ff;
   logic              out_load;
   logic              scan_start;

   logic              s_we, h_we;
   logic [SW-1:0]     s_waddr, s_raddr;
   logic [HW-1:0]     h_waddr, h_raddr;
   logic [DATA_W-1:0] s_wdata, h_wdata, s_rdata, h_rdata;

   logic              lag_in_range;
   logic [HW:0]       lag_pos_wide;
   logic [HW-1:0]     lag_pos;
   krwm_scan_ctl_type scan_ctl;
   logic [DATA_W-1:0] scan_sum, scan_peak, scan_lag;

   assign sptr_adv = (sptr_ff == SW'(SLICES_PER_WINDOW - 1)) ? '0 : sptr_ff + SW'(1);
   assign hptr_adv = (hptr_ff == HW'(HISTORY_DEPTH - 1)) ? '0 : hptr_ff + HW'(1);

   assign lag_in_range = ({1'b0, lag_ff} < (LAG_W+1)'(HISTORY_DEPTH));
   assign lag_pos_wide = ((HW+1)'(hptr_ff) >= (HW+1)'(lag_ff)) ?
                         (HW+1)'(hptr_ff) - (HW+1)'(lag_ff) :
                         (HW+1)'(hptr_ff) + (HW+1)'(HISTORY_DEPTH) - (HW+1)'(lag_ff);
   assign lag_pos = lag_pos_wide[HW-1:0];

   assign scan_ctl.start    = scan_start;
   assign scan_ctl.valid    = rd_valid_ff;
   assign scan_ctl.slice_ok = (rd_idx_ff < CW'(SLICES_PER_WINDOW));
   assign scan_ctl.hist_ok  = (rd_idx_ff < CW'(HISTORY_DEPTH));
   assign scan_ctl.lag_hit  = lag_in_range && (rd_idx_ff == CW'(lag_pos));

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      lag_in         = lag_ff;
      slice_count_in = slice_count_ff;
      sptr_in        = sptr_ff;
      hptr_in        = hptr_ff;
      out_load       = 1'b0;
      scan_start     = 1'b0;
      req_bus.ready  = 1'b0;
      s_we           = 1'b0;
      s_waddr        = sptr_ff;
      s_wdata        = '0;
      s_raddr        = sptr_ff;
      h_we           = 1'b0;
      h_waddr        = hptr_ff;
      h_wdata        = '0;
      h_raddr        = hptr_ff;
      case (state_ff)
         ST_CLEAR: begin
            s_we    = (idx_ff < CW'(SLICES_PER_WINDOW));
            s_waddr = SW'(idx_ff);
            h_we    = (idx_ff < CW'(HISTORY_DEPTH));
            h_waddr = HW'(idx_ff);
            if (idx_ff == CW'(SCAN_N - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               lag_in     = req_bus.lag;
               scan_start = 1'b1;
               idx_in     = '0;
               state_in   = ST_SCAN;
               case (krwm_cmd_type'(req_bus.cmd))
                  CMD_KEY: begin
                     slice_count_in = slice_count_ff + DATA_W'(1);
                  end
                  CMD_SLICE: begin
                     sptr_in        = sptr_adv;
                     s_we           = 1'b1;
                     s_waddr        = sptr_adv;
                     s_wdata        = slice_count_ff;
                     slice_count_in = '0;
                  end
                  CMD_HIST: begin
                     state_in = ST_WR_HIST;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WR_HIST: begin
            h_we     = 1'b1;
            h_waddr  = hptr_adv;
            h_wdata  = s_rdata;
            hptr_in  = hptr_adv;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            s_raddr = SW'(idx_ff);
            h_raddr = HW'(idx_ff);
            if (idx_ff == CW'(SCAN_N - 1)) begin
               idx_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         idx_ff         <= '0;
         rd_valid_ff    <= 1'b0;
         slice_count_ff <= '0;
         sptr_ff        <= '0;
         hptr_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         rd_valid_ff    <= (state_ff == ST_SCAN);
         slice_count_ff <= slice_count_in;
         sptr_ff        <= sptr_in;
         hptr_ff        <= hptr_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff;
      lag_ff    <= lag_in;
      if (out_load) begin
         rsp_sum_ff  <= scan_sum;
         rsp_peak_ff <= scan_peak;
         rsp_lag_ff  <= scan_lag;
      end
   end

   krwm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SLICES_PER_WINDOW)
   ) u_slice_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   krwm_ram #(
      .WIDTH (DATA_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   krwm_scan u_scan (
      .clock          (clock),
      .ctl            (scan_ctl),
      .slice_data     (s_rdata),
      .hist_data      (h_rdata),
      .rate_sum       (scan_sum),
      .history_peak   (scan_peak),
      .history_at_lag (scan_lag)
   );

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.rate_sum       = rsp_sum_ff;
   assign rsp_bus.history_peak   = rsp_peak_ff;
   assign rsp_bus.history_at_lag = rsp_lag_ff;

   a_hptr_only_on_hist_timer: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_WR_HIST) |=> $stable(hptr_ff))
      else $error("History pointer moved outside a history timer write.");

   a_slice_state_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> ($stable(slice_count_ff) && $stable(sptr_ff)))
      else $error("Slice state changed while no request was being accepted.");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid_ff && (rsp_sum_ff == $past(scan_sum))))
      else $error("Response register did not take the scan result.");

   a_read_data_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)))
      else $error("Scan read data arrived outside the scan.");

endmodule
